/* hdl/assert_macros.svh */
// Assertion macros shared by the slot table allocator RTL.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define SSTA_ASSERT_ALWAYS(label, c, r, expr, msg) \
    label: assert property (@(posedge c) disable iff (!r) (expr)) else $error(msg);

// A condition that implies another in the same cycle.
`define SSTA_ASSERT_IMPLIES(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another in the following cycle.
`define SSTA_ASSERT_NEXT(label, c, r, ante, cons, msg) \
    label: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ssta_pkg.sv */
// Package for the sparse slot table allocator: field widths, opcodes,
// status codes and the response record type. No dependencies.
`default_nettype none

package ssta_pkg;

    // Field widths of the request and response.
    localparam int OPCODE_W = 3;
    localparam int HANDLE_W = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_UPDATE = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd3;

    // Control part of one response.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] handle;
        logic                changed;
    } rsp_t;

endpackage

`default_nettype wire

/* hdl/sparse_slot_table_allocator_unit.sv */
// Sparse slot table allocator: slot valid bits, payload memory and a
// one-slot-per-cycle free slot scanner. Depends on ssta_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

// One request is taken at a time; req_stall is high from acceptance until the
// response has been placed in the output register. An add scans the valid bits
// one slot per cycle from slot 0 until it finds the lowest free slot, or up to
// the last slot when the table is full. Update, delete, clear and unused
// opcodes pass through the execute and response states; a read of an active
// slot adds a wait state for the registered read of the payload memory. A
// response held by rsp_stall delays the next acceptance. All slots are empty
// after reset with no clearing pass: valid bits gate every payload read.
module sparse_slot_table_allocator_unit #(
    parameter int NUM_SLOTS    = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // Request channel
    input  wire                              req_valid,
    output logic                             req_stall,
    input  wire  [ssta_pkg::OPCODE_W-1:0]    opcode,
    input  wire  [ssta_pkg::HANDLE_W-1:0]    handle,
    input  wire  [ssta_pkg::DATA_W-1:0]      payload,
    // Response channel
    output logic                             rsp_valid,
    input  wire                              rsp_stall,
    output logic [ssta_pkg::STATUS_W-1:0]    status,
    output logic [ssta_pkg::HANDLE_W-1:0]    handle_out,
    output logic [ssta_pkg::DATA_W-1:0]      payload_out,
    output logic [ssta_pkg::COUNT_W-1:0]     active_count,
    output logic                             changed
);

    localparam int DATA_W     = ssta_pkg::DATA_W;
    localparam int HANDLE_W   = ssta_pkg::HANDLE_W;
    localparam int COUNT_W    = ssta_pkg::COUNT_W;
    localparam int STORE_BITS = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;
    localparam int IDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
    // Wide enough for any handle and for NUM_SLOTS itself.
    localparam int CMP_W      = 9;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDWAIT = 3'd3;
    localparam logic [2:0] ST_RESP   = 3'd4;

    logic [2:0]                     state_reg, state_next;
    logic [ssta_pkg::OPCODE_W-1:0]  op_reg;
    logic [HANDLE_W-1:0]            hdl_reg;
    logic [STORE_BITS-1:0]          pl_reg;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]           valid_reg, valid_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    ssta_pkg::rsp_t                 res_reg, res_next;
    logic [STORE_BITS-1:0]          res_pl_reg, res_pl_next;

    // Payload memory, read data registered.
    logic [STORE_BITS-1:0]          mem [NUM_SLOTS];
    logic [STORE_BITS-1:0]          mem_rdata_reg;
    logic                           mem_we;
    logic                           mem_re;
    logic [IDX_W-1:0]               mem_addr;

    // Output register.
    logic                           rsp_valid_reg, rsp_valid_next;
    ssta_pkg::rsp_t                 out_rsp_reg;
    logic [STORE_BITS-1:0]          out_pl_reg;
    logic [COUNT_W-1:0]             out_cnt_reg;

    logic                           req_accept;
    logic                           rsp_load;
    logic [CMP_W-1:0]               hdl_sub;
    logic [IDX_W-1:0]               slot_idx;
    logic                           hdl_bad;
    logic                           slot_active;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_load   = (state_reg == ST_RESP) && (!rsp_valid_reg || !rsp_stall);

    // Handle decode: slot index is handle minus one.
    assign hdl_sub     = CMP_W'(hdl_reg) - CMP_W'(1);
    assign slot_idx    = hdl_sub[IDX_W-1:0];
    assign hdl_bad     = (hdl_reg == '0) || (CMP_W'(hdl_reg) > CMP_W'(NUM_SLOTS));
    assign slot_active = !hdl_bad && valid_reg[slot_idx];

    // Sequencer and slot bookkeeping.
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        count_next  = count_reg;
        res_next    = res_reg;
        res_pl_next = res_pl_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = slot_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next  = (opcode == ssta_pkg::OP_ADD) ? ST_SCAN : ST_EXEC;
                    idx_next    = '0;
                    res_next    = '{status: ssta_pkg::ST_OK, handle: '0, changed: 1'b0};
                    res_pl_next = '0;
                end
            end

            ST_SCAN:
            begin
                // One slot checked per cycle; the first free one takes the add.
                mem_addr = idx_reg;
                if (!valid_reg[idx_reg])
                begin
                    mem_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    count_next          = count_reg + CNT_W'(1);
                    res_next.handle     = HANDLE_W'(CMP_W'(idx_reg) + CMP_W'(1));
                    res_next.changed    = 1'b1;
                    state_next          = ST_RESP;
                end
                else if (idx_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    res_next.status = ssta_pkg::ST_FULL;
                    state_next      = ST_RESP;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_EXEC:
            begin
                state_next = ST_RESP;
                case (op_reg) inside
                    ssta_pkg::OP_UPDATE, ssta_pkg::OP_DELETE, ssta_pkg::OP_READ:
                    begin
                        if (hdl_bad)
                        begin
                            res_next.status = ssta_pkg::ST_BAD_HANDLE;
                        end
                        else if (op_reg == ssta_pkg::OP_READ)
                        begin
                            // Inactive slots read back as zero.
                            if (slot_active)
                            begin
                                res_next.handle = hdl_reg;
                                mem_re          = 1'b1;
                                state_next      = ST_RDWAIT;
                            end
                        end
                        else if (!slot_active)
                        begin
                            res_next.status = ssta_pkg::ST_NOT_FOUND;
                        end
                        else if (op_reg == ssta_pkg::OP_UPDATE)
                        begin
                            mem_we           = 1'b1;
                            res_next.changed = 1'b1;
                        end
                        else
                        begin
                            valid_next[slot_idx] = 1'b0;
                            count_next           = count_reg - CNT_W'(1);
                            res_next.changed     = 1'b1;
                        end
                    end
                    ssta_pkg::OP_CLEAR:
                    begin
                        valid_next       = '0;
                        count_next       = '0;
                        res_next.changed = 1'b1;
                    end
                    default:
                    begin
                        res_next.changed = 1'b0;
                    end
                endcase
            end

            ST_RDWAIT:
            begin
                res_pl_next = mem_rdata_reg;
                state_next  = ST_RESP;
            end

            ST_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid: loaded from the sequencer, cleared when taken.
    always_comb
    begin
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Request capture, scan index and response staging.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg  <= opcode;
            hdl_reg <= handle;
            pl_reg  <= STORE_BITS'(payload);
        end
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        res_pl_reg <= res_pl_next;
        if (rsp_load)
        begin
            out_rsp_reg <= res_reg;
            out_pl_reg  <= res_pl_reg;
            out_cnt_reg <= COUNT_W'(count_reg);
        end
    end

    // Payload memory: one write or one read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= pl_reg;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_addr];
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = out_rsp_reg.status;
    assign handle_out   = out_rsp_reg.handle;
    assign payload_out  = DATA_W'(out_pl_reg);
    assign active_count = out_cnt_reg;
    assign changed      = out_rsp_reg.changed;

    // Checks on the slot bookkeeping and the sequencer.
    `SSTA_ASSERT_ALWAYS(a_count_matches_valid, clk, rst_n, count_reg == CNT_W'($countones(valid_reg)), "active count differs from valid bits")
    `SSTA_ASSERT_NEXT(a_add_bumps_count, clk, rst_n, (state_reg == ST_SCAN) && !valid_reg[idx_reg], count_reg == $past(count_reg) + CNT_W'(1), "add did not increment count")
    `SSTA_ASSERT_NEXT(a_clear_empties, clk, rst_n, (state_reg == ST_EXEC) && (op_reg == ssta_pkg::OP_CLEAR), valid_reg == '0, "clear left active slots")
    `SSTA_ASSERT_IMPLIES(a_rsp_from_resp, clk, rst_n, $rose(rsp_valid_reg), $past(state_reg) == ST_RESP, "response raised outside response state")

endmodule

`default_nettype wire

/* bench/sparse_slot_table_allocator_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the sparse slot table allocator: queued request driver,
// response monitor with a slot table predictor. Depends on ssta_pkg and the unit.

module sparse_slot_table_allocator_unit_tb;

    localparam int NUM_SLOTS    = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int OPCODE_W = ssta_pkg::OPCODE_W;
    localparam int HANDLE_W = ssta_pkg::HANDLE_W;
    localparam int DATA_W   = ssta_pkg::DATA_W;
    localparam int STATUS_W = ssta_pkg::STATUS_W;
    localparam int COUNT_W  = ssta_pkg::COUNT_W;

    // Opcodes the block treats as no operation.
    localparam logic [OPCODE_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_C = 3'd7;

    localparam int RANDOM_REQS  = 450;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [HANDLE_W-1:0] hnd;
        logic [DATA_W-1:0]   word;
    } table_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] hnd;
        logic [DATA_W-1:0]   word;
        logic [COUNT_W-1:0]  count;
        logic                chg;
    } table_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [HANDLE_W-1:0] handle = '0;
    logic [DATA_W-1:0]   payload = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [DATA_W-1:0]   payload_out;
    logic [COUNT_W-1:0]  active_count;
    logic                changed;

    table_req_t    pending_reqs[$];
    table_result_t table_results[$];

    int total_reqs   = 0;
    int accept_count = 0;
    int sent_count   = 0;
    int fail_count   = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    // Predicted table contents.
    bit                 slot_used [NUM_SLOTS];
    logic [DATA_W-1:0]  slot_word [NUM_SLOTS];
    int unsigned        used_total = 0;

    sparse_slot_table_allocator_unit #(
        .NUM_SLOTS    (NUM_SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .opcode       (opcode),
        .handle       (handle),
        .payload      (payload),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .handle_out   (handle_out),
        .payload_out  (payload_out),
        .active_count (active_count),
        .changed      (changed)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the predicted table and returns the response it causes.
    function automatic table_result_t apply_table_op(table_req_t rq);
        table_result_t r;
        int            idx;
        bit            found;
        r = '0;
        r.status = ssta_pkg::ST_OK;
        found = 1'b0;
        case (rq.op)
            ssta_pkg::OP_ADD:
            begin
                r.status = ssta_pkg::ST_FULL;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && !slot_used[i])
                    begin
                        found = 1'b1;
                        slot_used[i] = 1'b1;
                        slot_word[i] = rq.word;
                        used_total++;
                        r.hnd = HANDLE_W'(i + 1);
                        r.status = ssta_pkg::ST_OK;
                        r.chg = 1'b1;
                    end
                end
            end
            ssta_pkg::OP_UPDATE, ssta_pkg::OP_DELETE, ssta_pkg::OP_READ:
            begin
                if (rq.hnd == 0 || rq.hnd > NUM_SLOTS)
                begin
                    r.status = ssta_pkg::ST_BAD_HANDLE;
                end
                else
                begin
                    idx = int'(rq.hnd) - 1;
                    if (rq.op == ssta_pkg::OP_READ)
                    begin
                        if (slot_used[idx])
                        begin
                            r.hnd = rq.hnd;
                            r.word = slot_word[idx];
                        end
                    end
                    else if (!slot_used[idx])
                    begin
                        r.status = ssta_pkg::ST_NOT_FOUND;
                    end
                    else if (rq.op == ssta_pkg::OP_UPDATE)
                    begin
                        slot_word[idx] = rq.word;
                        r.chg = 1'b1;
                    end
                    else
                    begin
                        slot_used[idx] = 1'b0;
                        slot_word[idx] = '0;
                        used_total--;
                        r.chg = 1'b1;
                    end
                end
            end
            ssta_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    slot_used[i] = 1'b0;
                    slot_word[i] = '0;
                end
                used_total = 0;
                r.chg = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_W'(used_total);
        return r;
    endfunction

    // Mostly legal handles, with zero and out-of-range values mixed in.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return HANDLE_W'($urandom_range(NUM_SLOTS, 1));
        else if (roll < 92)
            return '0;
        else
            return HANDLE_W'($urandom_range(31, NUM_SLOTS + 1));
    endfunction

    function automatic table_req_t random_req(bit add_only);
        table_req_t rq;
        int         roll;
        rq.hnd  = pick_handle();
        rq.word = $urandom;
        roll = add_only ? 0 : $urandom_range(99);
        if (roll < 25)
            rq.op = ssta_pkg::OP_ADD;
        else if (roll < 40)
            rq.op = ssta_pkg::OP_UPDATE;
        else if (roll < 60)
            rq.op = ssta_pkg::OP_DELETE;
        else if (roll < 88)
            rq.op = ssta_pkg::OP_READ;
        else if (roll < 92)
            rq.op = ssta_pkg::OP_CLEAR;
        else
            rq.op = OPCODE_W'($urandom_range(OP_SPARE_C, OP_SPARE_A));
        return rq;
    endfunction

    task automatic push_req(logic [OPCODE_W-1:0] op, logic [HANDLE_W-1:0] h,
                            logic [DATA_W-1:0] w);
        table_req_t rq;
        rq.op   = op;
        rq.hnd  = h;
        rq.word = w;
        pending_reqs.push_back(rq);
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] exp_v,
                               logic [DATA_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Idle rates: receiver-heavy first, sender-heavy second, none in the last third.
    function automatic int sender_idle_pct();
        if (accept_count < total_reqs / 3)
            return 36;
        else if (accept_count < (2 * total_reqs) / 3)
            return 62;
        else
            return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (accept_count < total_reqs / 3)
            return 62;
        else if (accept_count < (2 * total_reqs) / 3)
            return 36;
        else
            return 0;
    endfunction

    // Request driver: holds an offered request until it is taken.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (req_valid && accept_count != sent_count)
        begin
        end
        else if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct())
        begin
            table_req_t rq;
            rq = pending_reqs.pop_front();
            req_valid  <= 1'b1;
            opcode     <= rq.op;
            handle     <= rq.hnd;
            payload    <= rq.word;
            sent_count <= sent_count + 1;
        end
        else
        begin
            req_valid <= 1'b0;
        end
    end

    // Response stall: one long hold-off so the block backs up, random stalls otherwise.
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accept_count >= HOLD_AT)
        begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
        end
    end

    // Monitor: checks taken responses, then predicts for a taken request.
    always @(posedge clk)
    begin
        table_result_t got;
        table_result_t want;
        table_req_t    rq;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                got = '{status, handle_out, payload_out, active_count, changed};
                if (table_results.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %0h",
                             $time, got);
                    fail_count++;
                end
                else
                begin
                    want = table_results.pop_front();
                    check_field("status", DATA_W'(want.status), DATA_W'(got.status));
                    check_field("handle_out", DATA_W'(want.hnd), DATA_W'(got.hnd));
                    check_field("payload_out", want.word, got.word);
                    check_field("active_count", DATA_W'(want.count), DATA_W'(got.count));
                    check_field("changed", DATA_W'(want.chg), DATA_W'(got.chg));
                end
            end
            if (req_valid && !req_stall)
            begin
                rq = '{opcode, handle, payload};
                table_results.push_back(apply_table_op(rq));
                accept_count <= accept_count + 1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int n;
        bit fill_burst;

        // Directed part: edge payloads, every operation, bad handles and missing slots.
        push_req(ssta_pkg::OP_READ,   5'd1,  32'h0);
        push_req(ssta_pkg::OP_ADD,    5'd0,  32'h0000_0000);
        push_req(ssta_pkg::OP_ADD,    5'd0,  32'hFFFF_FFFF);
        push_req(ssta_pkg::OP_READ,   5'd1,  32'h0);
        push_req(ssta_pkg::OP_READ,   5'd2,  32'h0);
        push_req(ssta_pkg::OP_UPDATE, 5'd1,  32'hA5A5_5A5A);
        push_req(ssta_pkg::OP_READ,   5'd1,  32'h0);
        push_req(ssta_pkg::OP_DELETE, 5'd2,  32'h0);
        push_req(ssta_pkg::OP_READ,   5'd2,  32'h0);
        push_req(ssta_pkg::OP_UPDATE, 5'd2,  32'h1234_5678);
        push_req(ssta_pkg::OP_DELETE, 5'd2,  32'h0);
        push_req(ssta_pkg::OP_READ,   5'd0,  32'h0);
        push_req(ssta_pkg::OP_UPDATE, 5'd17, 32'hDEAD_BEEF);
        push_req(ssta_pkg::OP_DELETE, 5'd31, 32'hFFFF_FFFF);
        push_req(OP_SPARE_A, 5'd1, 32'h5555_5555);
        push_req(OP_SPARE_B, 5'd16, 32'hAAAA_AAAA);
        push_req(OP_SPARE_C, 5'd31, 32'hFFFF_FFFF);
        push_req(ssta_pkg::OP_ADD,    5'd0,  32'h8000_0001);
        push_req(ssta_pkg::OP_READ,   5'd16, 32'h0);
        push_req(ssta_pkg::OP_CLEAR,  5'd0,  32'h0);
        push_req(ssta_pkg::OP_CLEAR,  5'd0,  32'h0);
        push_req(ssta_pkg::OP_READ,   5'd1,  32'h0);

        // Random part: bursts of adds that run the table full, between mixed runs.
        n = 0;
        while (n < RANDOM_REQS)
        begin
            fill_burst = ($urandom_range(5) == 0);
            for (int i = 0; i < (fill_burst ? NUM_SLOTS + 2 : 20); i++)
            begin
                pending_reqs.push_back(random_req(fill_burst));
                n++;
            end
        end
        total_reqs = pending_reqs.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accept_count != total_reqs || table_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("sparse_slot_table_allocator_unit test passed");
        else
            $display("sparse_slot_table_allocator_unit test failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #4000000;
        $display("sparse_slot_table_allocator_unit test failed");
        $finish;
    end

endmodule
